>>> rtl/qvr_pkg.sv
// Shared widths, types, register indexes and rounding helpers for the vertex rotate core.
package qvr_pkg;

  // Field formats
  localparam int COORD_WIDTH    = 32;
  localparam int QUAT_FRAC_BITS = 16;
  localparam int QUAT_WIDTH     = QUAT_FRAC_BITS + 2;

  // Configuration port
  localparam int NUM_REGS   = 7;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_DATA_W = (COORD_WIDTH > QUAT_WIDTH) ? COORD_WIDTH : QUAT_WIDTH;

  // Stream payload widths, rounded up to whole bytes
  localparam int TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

  // Pipeline depth: diff, mul, sum, mul, sum, clamp
  localparam int NUM_STAGES = 6;
  localparam int HALF_STAGES = NUM_STAGES / 2;

  // Internal widths, all exact
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int P1_W   = QUAT_WIDTH + DIFF_W;
  localparam int S1_W   = P1_W + 2;
  localparam int T_W    = S1_W - QUAT_FRAC_BITS;
  localparam int P2_W   = T_W + QUAT_WIDTH;
  localparam int S2_W   = P2_W + 2;
  localparam int R_W    = S2_W - QUAT_FRAC_BITS;
  localparam int SUM_W  = R_W + 1;

  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [P1_W-1:0]    p1_t;
  typedef logic signed [S1_W-1:0]    s1_t;
  typedef logic signed [T_W-1:0]     t_t;
  typedef logic signed [P2_W-1:0]    p2_t;
  typedef logic signed [S2_W-1:0]    s2_t;
  typedef logic signed [R_W-1:0]     r_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // Register indexes
  localparam cfg_idx_t REG_QUAT_W  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_QUAT_X  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_QUAT_Y  = cfg_idx_t'(2);
  localparam cfg_idx_t REG_QUAT_Z  = cfg_idx_t'(3);
  localparam cfg_idx_t REG_PIVOT_X = cfg_idx_t'(4);
  localparam cfg_idx_t REG_PIVOT_Y = cfg_idx_t'(5);
  localparam cfg_idx_t REG_PIVOT_Z = cfg_idx_t'(6);

  localparam quat_t  QUAT_ONE  = {{(QUAT_WIDTH-QUAT_FRAC_BITS-1){1'b0}}, 1'b1,
                                  {QUAT_FRAC_BITS{1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Quaternion and pivot as seen by the datapath; pivot[0] is x
  typedef struct packed {
    quat_t            w;
    quat_t            x;
    quat_t            y;
    quat_t            z;
    coord_t [2:0]     pivot;
  } cfg_t;

  // Round half up and drop the quaternion fraction bits
  function automatic t_t round_t(s1_t acc);
    s1_t tmp;
    tmp = acc + $signed({{(S1_W-QUAT_FRAC_BITS){1'b0}}, 1'b1, {(QUAT_FRAC_BITS-1){1'b0}}});
    return t_t'(tmp >>> QUAT_FRAC_BITS);
  endfunction

  function automatic r_t round_r(s2_t acc);
    s2_t tmp;
    tmp = acc + $signed({{(S2_W-QUAT_FRAC_BITS){1'b0}}, 1'b1, {(QUAT_FRAC_BITS-1){1'b0}}});
    return r_t'(tmp >>> QUAT_FRAC_BITS);
  endfunction

endpackage

>>> rtl/qvr_conj_half.sv
// First half of the datapath: pivot offset and the product conj(q) * (0, d).
module qvr_conj_half (
  input  logic                                clk_i,
  input  logic [qvr_pkg::HALF_STAGES-1:0]     ld_i,
  input  qvr_pkg::cfg_t                       cfg_i,
  input  qvr_pkg::coord_t                     vertex_i [3],
  output qvr_pkg::t_t                         t_o [4]
);
  import qvr_pkg::*;

  diff_t d_q [3];
  p1_t   m_q [12];
  t_t    t_q [4];

  // Stage one: offset from the pivot
  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= diff_t'(vertex_i[i]) - diff_t'(cfg_i.pivot[i]);
      end
    end
  end

  // Stage two: the twelve partial products, grouped by component of t
  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      m_q[0]  <= p1_t'(cfg_i.x) * p1_t'(d_q[0]);
      m_q[1]  <= p1_t'(cfg_i.y) * p1_t'(d_q[1]);
      m_q[2]  <= p1_t'(cfg_i.z) * p1_t'(d_q[2]);
      m_q[3]  <= p1_t'(cfg_i.w) * p1_t'(d_q[0]);
      m_q[4]  <= p1_t'(cfg_i.y) * p1_t'(d_q[2]);
      m_q[5]  <= p1_t'(cfg_i.z) * p1_t'(d_q[1]);
      m_q[6]  <= p1_t'(cfg_i.w) * p1_t'(d_q[1]);
      m_q[7]  <= p1_t'(cfg_i.x) * p1_t'(d_q[2]);
      m_q[8]  <= p1_t'(cfg_i.z) * p1_t'(d_q[0]);
      m_q[9]  <= p1_t'(cfg_i.w) * p1_t'(d_q[2]);
      m_q[10] <= p1_t'(cfg_i.x) * p1_t'(d_q[1]);
      m_q[11] <= p1_t'(cfg_i.y) * p1_t'(d_q[0]);
    end
  end

  // Stage three: sum and round each component
  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      t_q[0] <= round_t(s1_t'(m_q[0]) + s1_t'(m_q[1]) + s1_t'(m_q[2]));
      t_q[1] <= round_t(s1_t'(m_q[3]) - s1_t'(m_q[4]) + s1_t'(m_q[5]));
      t_q[2] <= round_t(s1_t'(m_q[6]) + s1_t'(m_q[7]) - s1_t'(m_q[8]));
      t_q[3] <= round_t(s1_t'(m_q[9]) - s1_t'(m_q[10]) + s1_t'(m_q[11]));
    end
  end

  assign t_o = t_q;

endmodule

>>> rtl/qvr_rot_half.sv
// Second half of the datapath: vector part of t * q, pivot add-back and clamp.
module qvr_rot_half (
  input  logic                                clk_i,
  input  logic [qvr_pkg::HALF_STAGES-1:0]     ld_i,
  input  qvr_pkg::cfg_t                       cfg_i,
  input  qvr_pkg::t_t                         t_i [4],
  output qvr_pkg::coord_t                     rotated_o [3],
  output logic                                saturated_o
);
  import qvr_pkg::*;

  localparam sum_t SUM_MAX = sum_t'(COORD_MAX);
  localparam sum_t SUM_MIN = sum_t'(COORD_MIN);

  p2_t    n_q [12];
  r_t     r_q [3];
  coord_t rot_q [3];
  logic   sat_q;

  sum_t   sum [3];
  coord_t rot_d [3];
  logic   sat_d;

  // Stage four: partial products of t with q; t[0] is the scalar part
  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      n_q[0]  <= p2_t'(t_i[0]) * p2_t'(cfg_i.x);
      n_q[1]  <= p2_t'(t_i[1]) * p2_t'(cfg_i.w);
      n_q[2]  <= p2_t'(t_i[2]) * p2_t'(cfg_i.z);
      n_q[3]  <= p2_t'(t_i[3]) * p2_t'(cfg_i.y);
      n_q[4]  <= p2_t'(t_i[0]) * p2_t'(cfg_i.y);
      n_q[5]  <= p2_t'(t_i[1]) * p2_t'(cfg_i.z);
      n_q[6]  <= p2_t'(t_i[2]) * p2_t'(cfg_i.w);
      n_q[7]  <= p2_t'(t_i[3]) * p2_t'(cfg_i.x);
      n_q[8]  <= p2_t'(t_i[0]) * p2_t'(cfg_i.z);
      n_q[9]  <= p2_t'(t_i[1]) * p2_t'(cfg_i.y);
      n_q[10] <= p2_t'(t_i[2]) * p2_t'(cfg_i.x);
      n_q[11] <= p2_t'(t_i[3]) * p2_t'(cfg_i.w);
    end
  end

  // Stage five: sum and round each vector component
  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      r_q[0] <= round_r(s2_t'(n_q[0]) + s2_t'(n_q[1]) + s2_t'(n_q[2]) - s2_t'(n_q[3]));
      r_q[1] <= round_r(s2_t'(n_q[4]) - s2_t'(n_q[5]) + s2_t'(n_q[6]) + s2_t'(n_q[7]));
      r_q[2] <= round_r(s2_t'(n_q[8]) + s2_t'(n_q[9]) - s2_t'(n_q[10]) + s2_t'(n_q[11]));
    end
  end

  // Add the pivot back and clamp to the coordinate range
  always_comb begin
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum[i] = sum_t'(r_q[i]) + sum_t'(cfg_i.pivot[i]);
      if (sum[i] > SUM_MAX) begin
        rot_d[i] = COORD_MAX;
        sat_d    = 1'b1;
      end else if (sum[i] < SUM_MIN) begin
        rot_d[i] = COORD_MIN;
        sat_d    = 1'b1;
      end else begin
        rot_d[i] = coord_t'(sum[i]);
      end
    end
  end

  // Stage six: output register
  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      rot_q <= rot_d;
      sat_q <= sat_d;
    end
  end

  assign rotated_o   = rot_q;
  assign saturated_o = sat_q;

endmodule

>>> rtl/quaternion_vertex_rotate_core.sv
// Top level of the quaternion vertex rotate core: configuration, stall control, datapath.
//
// Rotates each vertex about the configured pivot by the configured quaternion q,
// computing conj(q) * (0, v - p) * q and adding the pivot back; a non-unit q also
// scales by |q|^2. Results are rounded half up at each product and saturated to
// Q16.16, with the saturated flag on tuser. The datapath is a six-stage pipeline
// (offset, products, sums, products, sums, clamp) and can take one beat every
// cycle while the output accepts. Ready stalls ripple back only through full stages,
// so bubbles close up under back-pressure. Configuration should only be written
// while the pipeline is empty.
module quaternion_vertex_rotate_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  qvr_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [qvr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // vertex stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [qvr_pkg::TDATA_W-1:0]   s_axis_tdata,  // vertex_x, vertex_y, vertex_z
  // rotated stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [qvr_pkg::TDATA_W-1:0]   m_axis_tdata,  // rotated_x, rotated_y, rotated_z
  output logic                          m_axis_tuser   // saturated
);
  import qvr_pkg::*;

  cfg_t   cfg_q;
  logic   run_q;
  logic [NUM_STAGES-1:0] vld_q, vld_d, vin, rdy, ld;

  coord_t vertex [3];
  coord_t rotated [3];
  t_t     t_mid [4];
  logic   sat;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.w     <= QUAT_ONE;
      cfg_q.x     <= '0;
      cfg_q.y     <= '0;
      cfg_q.z     <= '0;
      cfg_q.pivot <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_QUAT_W:  cfg_q.w        <= quat_t'(cfg_data_i);
        REG_QUAT_X:  cfg_q.x        <= quat_t'(cfg_data_i);
        REG_QUAT_Y:  cfg_q.y        <= quat_t'(cfg_data_i);
        REG_QUAT_Z:  cfg_q.z        <= quat_t'(cfg_data_i);
        REG_PIVOT_X: cfg_q.pivot[0] <= coord_t'(cfg_data_i);
        REG_PIVOT_Y: cfg_q.pivot[1] <= coord_t'(cfg_data_i);
        REG_PIVOT_Z: cfg_q.pivot[2] <= coord_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Hold off the input until the first cycle out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= 1'b1;
    end
  end

  // Stage loads: a stage advances when empty or when the one after it advances
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vin = {vld_q[NUM_STAGES-2:0], s_axis_tvalid && run_q};
    ld  = rdy & vin;
    for (int k = 0; k < NUM_STAGES; k++) begin
      vld_d[k] = rdy[k] ? vin[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Unpack the input beat
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vertex[i] = s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  qvr_conj_half u_conj (
    .clk_i    (clk_i),
    .ld_i     (ld[HALF_STAGES-1:0]),
    .cfg_i    (cfg_q),
    .vertex_i (vertex),
    .t_o      (t_mid)
  );

  qvr_rot_half u_rot (
    .clk_i       (clk_i),
    .ld_i        (ld[NUM_STAGES-1:HALF_STAGES]),
    .cfg_i       (cfg_q),
    .t_i         (t_mid),
    .rotated_o   (rotated),
    .saturated_o (sat)
  );

  // Pack the output beat
  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH] = rotated[i];
    end
  end

  assign s_axis_tready = rdy[0] && run_q;
  assign m_axis_tvalid = vld_q[NUM_STAGES-1];
  assign m_axis_tuser  = sat;

  // Input only backs up when every stage is full and the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && !s_axis_tready) |-> ((&vld_q) && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  // Beats in flight change only by accepted input and delivered output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(vld_q) == $past($countones(vld_q))
      + $past(int'(s_axis_tvalid && s_axis_tready))
      - $past(int'(m_axis_tvalid && m_axis_tready))))
    else $error("beat lost or duplicated in the pipeline");

  // A saturated beat carries at least one clamped coordinate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (rotated[0] == COORD_MAX || rotated[0] == COORD_MIN ||
       rotated[1] == COORD_MAX || rotated[1] == COORD_MIN ||
       rotated[2] == COORD_MAX || rotated[2] == COORD_MIN))
    else $error("saturated flag without a clamped coordinate");

endmodule
